### design/pwt_pkg.sv
// ----------------------------------------------------------------------------
// pwt_pkg
// Types, codes and helper functions shared by the wire tokenizer modules.
// ----------------------------------------------------------------------------
package pwt_pkg;

   localparam int FIELD_SLOTS      = 64;
   localparam int SLOT_W           = $clog2(FIELD_SLOTS);
   localparam int MAX_VARINT_BYTES = 10;
   localparam int MAX_TOKENS       = 4;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

   localparam logic [28:0] FIELD_MAX = 29'h1FFF_FFFF;

   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   localparam logic [2:0] TK_FIELD   = 3'd0;
   localparam logic [2:0] TK_UNKNOWN = 3'd1;
   localparam logic [2:0] TK_START   = 3'd2;
   localparam logic [2:0] TK_END_SEQ = 3'd3;
   localparam logic [2:0] TK_END_MSG = 3'd4;
   localparam logic [2:0] TK_ERROR   = 3'd5;

   localparam logic [3:0] ERR_NONE    = 4'd0;
   localparam logic [3:0] ERR_TAG     = 4'd1;
   localparam logic [3:0] ERR_VARINT  = 4'd2;
   localparam logic [3:0] ERR_LENGTH  = 4'd3;
   localparam logic [3:0] ERR_OVERRUN = 4'd4;
   localparam logic [3:0] ERR_FIXED64 = 4'd5;
   localparam logic [3:0] ERR_FIXED32 = 4'd6;
   localparam logic [3:0] ERR_WIRE    = 4'd7;
   localparam logic [3:0] ERR_EMPTY   = 4'd8;
   localparam logic [3:0] ERR_ELEMENT = 4'd9;

   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LENGTH  = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   localparam logic [1:0] SEQ_NONE     = 2'd0;
   localparam logic [1:0] SEQ_UNPACKED = 2'd1;
   localparam logic [1:0] SEQ_PACKED   = 2'd2;

   localparam logic [1:0] VI_MORE = 2'd0;
   localparam logic [1:0] VI_DONE = 2'd1;
   localparam logic [1:0] VI_LONG = 2'd2;

   typedef enum logic [1:0] {
      CL_FIELD,
      CL_UNKNOWN,
      CL_REP,
      CL_PACKED
   } class_type;

   typedef enum logic [3:0] {
      PH_TAG,
      PH_VAL,
      PH_LEN,
      PH_FIX,
      PH_SKIP,
      PH_PACK
   } phase_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
      logic       end_of_message;
      logic [5:0] slot_index;
      logic       slot_known;
      logic       slot_repeated;
      logic [2:0] slot_wtype;
   } req_type;

   typedef struct packed {
      logic [2:0]  token;
      logic [28:0] field_id;
      logic [2:0]  wire_kind;
      logic [63:0] value;
      logic [31:0] payload_offset;
      logic [3:0]  error_code;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      rsp_type [MAX_TOKENS-1:0] tok;
      logic [2:0]               n;
   } bundle_type;

   typedef struct packed {
      phase_type   ph;
      logic [63:0] acc;
      logic [3:0]  cnt;
      logic [31:0] brem;
      logic [31:0] prem;
      logic [31:0] off;
      logic [28:0] cf;
      logic [2:0]  cw;
      logic [1:0]  sm;
      logic        err;
   } st_type;

   typedef struct packed {
      logic [63:0] acc;
      logic [3:0]  cnt;
      logic [1:0]  res;
   } vint_type;

   typedef struct packed {
      logic [63:0] acc;
      logic [3:0]  cnt;
      logic        done;
   } fix_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic rsp_type mk_tok(logic [2:0] tk, logic [28:0] f, logic [2:0] w,
                                      logic [63:0] v, logic [31:0] o, logic [3:0] e);
      rsp_type r;
      r.token          = tk;
      r.field_id       = f;
      r.wire_kind      = w;
      r.value          = v;
      r.payload_offset = o;
      r.error_code     = e;
      r.last_result    = 1'b0;
      return r;
   endfunction

   function automatic bundle_type push(bundle_type b, rsp_type t);
      bundle_type r;
      r = b;
      if (r.n < 3'(MAX_TOKENS)) begin
         r.tok[r.n[1:0]] = t;
         r.n = r.n + 3'd1;
      end
      return r;
   endfunction

   function automatic vint_type vint(logic [63:0] acc, logic [3:0] cnt, logic [7:0] b);
      vint_type r;
      r.acc = acc;
      if (cnt < 4'(MAX_VARINT_BYTES)) begin
         r.acc = acc | ({57'd0, b[6:0]} << (7 * int'(cnt)));
      end
      r.cnt = cnt + 4'd1;
      if (!b[7]) begin
         r.res = VI_DONE;
      end else if (r.cnt >= 4'(MAX_VARINT_BYTES)) begin
         r.res = VI_LONG;
      end else begin
         r.res = VI_MORE;
      end
      return r;
   endfunction

   function automatic fix_type fixb(logic [63:0] acc, logic [3:0] cnt, logic [7:0] b,
                                    logic [2:0] w);
      fix_type r;
      r.acc = acc;
      if (cnt < 4'd8) begin
         r.acc = acc | ({56'd0, b} << (8 * int'(cnt)));
      end
      r.cnt  = cnt + 4'd1;
      r.done = r.cnt >= ((w == WT_FIXED64) ? 4'd8 : 4'd4);
      return r;
   endfunction

   // entry: {wtype[2:0], repeated, known}
   function automatic class_type classify(logic [2:0] w, logic [4:0] ent);
      class_type c;
      if (!ent[0]) begin
         c = CL_UNKNOWN;
      end else if (ent[1]) begin
         if (w == WT_LENGTH && (ent[4:2] == WT_VARINT || ent[4:2] == WT_FIXED64 ||
                                ent[4:2] == WT_FIXED32)) begin
            c = CL_PACKED;
         end else begin
            c = (ent[4:2] == w) ? CL_REP : CL_UNKNOWN;
         end
      end else begin
         c = (ent[4:2] == w) ? CL_FIELD : CL_UNKNOWN;
      end
      return c;
   endfunction

endpackage

### design/pwt_front.sv
// ----------------------------------------------------------------------------
// pwt_front
// Byte parser: field table, wire-format state and token bundle generation.
// ----------------------------------------------------------------------------
module pwt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pwt_pkg::req_type    req_data,
   input  pwt_pkg::qstat_type  qstat,
   output logic                push_valid,
   output pwt_pkg::bundle_type push_data
);

   pwt_pkg::st_type               st_ff, st_in;
   logic [4:0]                    ent_ff, ent_in;
   logic [pwt_pkg::FIELD_SLOTS-1:0] valid_ff;
   logic [4:0]                    slot_mem [pwt_pkg::FIELD_SLOTS];
   logic                          take;
   logic                          tag_load;
   logic [28:0]                   tag_f;
   logic [4:0]                    wr_ent;
   logic [pwt_pkg::SLOT_W-1:0]    wr_addr;
   logic [pwt_pkg::SLOT_W-1:0]    rd_addr;
   pwt_pkg::bundle_type           bnd;

   assign req_stall = qstat.full;
   assign take      = req_valid && !req_stall;
   assign wr_ent    = {req_data.slot_wtype, req_data.slot_repeated, req_data.slot_known};
   assign wr_addr   = pwt_pkg::SLOT_W'(req_data.slot_index);
   assign rd_addr   = tag_f[pwt_pkg::SLOT_W-1:0];

   always_comb begin
      pwt_pkg::st_type    s;
      pwt_pkg::st_type    clr;
      pwt_pkg::vint_type  v;
      pwt_pkg::fix_type   fx;
      pwt_pkg::class_type cl;
      logic [31:0]        o;
      logic               do_cf;
      logic [63:0]        cf_val;
      logic [31:0]        cf_off;
      logic               done;
      logic               stop;
      logic [3:0]         code;

      s        = st_ff;
      clr      = '0;
      clr.ph   = pwt_pkg::PH_TAG;
      bnd      = '0;
      tag_load = 1'b0;
      tag_f    = '0;
      do_cf    = 1'b0;
      cf_val   = '0;
      cf_off   = '0;
      o        = st_ff.off;
      v        = '0;
      fx       = '0;
      cl       = pwt_pkg::CL_UNKNOWN;
      done     = 1'b0;
      stop     = 1'b0;
      code     = pwt_pkg::ERR_NONE;

      if (take && req_data.operation == pwt_pkg::OP_BYTE && !s.err) begin
         unique case (s.ph)
            pwt_pkg::PH_VAL: begin
               v = pwt_pkg::vint(s.acc, s.cnt, req_data.data_byte);
               s.acc = v.acc;
               s.cnt = v.cnt;
               if (v.res == pwt_pkg::VI_LONG) begin
                  bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_ERROR, '0, '0, '0, '0,
                                                           pwt_pkg::ERR_VARINT));
                  s.err = 1'b1;
               end else if (v.res == pwt_pkg::VI_DONE) begin
                  do_cf  = 1'b1;
                  cf_val = s.acc;
               end
            end
            pwt_pkg::PH_FIX: begin
               fx = pwt_pkg::fixb(s.acc, s.cnt, req_data.data_byte, s.cw);
               s.acc = fx.acc;
               s.cnt = fx.cnt;
               if (fx.done) begin
                  do_cf  = 1'b1;
                  cf_val = s.acc;
               end
            end
            pwt_pkg::PH_LEN: begin
               v = pwt_pkg::vint(s.acc, s.cnt, req_data.data_byte);
               s.acc = v.acc;
               s.cnt = v.cnt;
               if (v.res == pwt_pkg::VI_LONG) begin
                  bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_ERROR, '0, '0, '0, '0,
                                                           pwt_pkg::ERR_LENGTH));
                  s.err = 1'b1;
               end else if (v.res == pwt_pkg::VI_DONE) begin
                  cl = pwt_pkg::classify(pwt_pkg::WT_LENGTH, ent_ff);
                  if (cl == pwt_pkg::CL_PACKED) begin
                     if (s.acc == '0) begin
                        bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_ERROR, '0, '0,
                                                                 '0, '0, pwt_pkg::ERR_EMPTY));
                        s.err = 1'b1;
                     end else if (s.acc[63:32] != '0) begin
                        bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_ERROR, '0, '0,
                                                                 '0, '0, pwt_pkg::ERR_OVERRUN));
                        s.err = 1'b1;
                     end else begin
                        if (s.sm != pwt_pkg::SEQ_NONE) begin
                           bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_END_SEQ, s.cf,
                              (s.sm == pwt_pkg::SEQ_PACKED) ? pwt_pkg::WT_LENGTH : s.cw,
                              '0, '0, pwt_pkg::ERR_NONE));
                        end
                        s.cw   = ent_ff[4:2];
                        s.prem = s.acc[31:0];
                        s.sm   = pwt_pkg::SEQ_PACKED;
                        bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_START, s.cf,
                           pwt_pkg::WT_LENGTH, s.acc, o + 32'd1, pwt_pkg::ERR_NONE));
                        s.acc = '0;
                        s.cnt = '0;
                        s.ph  = pwt_pkg::PH_PACK;
                     end
                  end else if (s.acc[63:32] != '0) begin
                     bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_ERROR, '0, '0, '0, '0,
                                                              pwt_pkg::ERR_OVERRUN));
                     s.err = 1'b1;
                  end else if (s.acc == '0) begin
                     do_cf  = 1'b1;
                     cf_val = '0;
                     cf_off = o + 32'd1;
                  end else begin
                     s.brem = s.acc[31:0];
                     s.cnt  = '0;
                     s.ph   = pwt_pkg::PH_SKIP;
                  end
               end
            end
            pwt_pkg::PH_SKIP: begin
               s.brem = s.brem - 32'd1;
               if (s.brem == '0) begin
                  do_cf  = 1'b1;
                  cf_val = s.acc;
                  cf_off = o + 32'd1 - s.acc[31:0];
               end
            end
            pwt_pkg::PH_PACK: begin
               s.prem = s.prem - 32'd1;
               if (s.cw == pwt_pkg::WT_VARINT) begin
                  v = pwt_pkg::vint(s.acc, s.cnt, req_data.data_byte);
                  s.acc = v.acc;
                  s.cnt = v.cnt;
                  if (v.res == pwt_pkg::VI_LONG) begin
                     bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_ERROR, '0, '0, '0,
                                                              '0, pwt_pkg::ERR_ELEMENT));
                     s.err = 1'b1;
                     stop  = 1'b1;
                  end
                  done = (v.res == pwt_pkg::VI_DONE);
               end else begin
                  fx = pwt_pkg::fixb(s.acc, s.cnt, req_data.data_byte, s.cw);
                  s.acc = fx.acc;
                  s.cnt = fx.cnt;
                  done  = fx.done;
               end
               if (!stop) begin
                  if (done) begin
                     bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_FIELD, s.cf, s.cw,
                                                              s.acc, '0, pwt_pkg::ERR_NONE));
                     s.acc = '0;
                     s.cnt = '0;
                  end
                  if (s.prem == '0) begin
                     if (s.cnt != '0) begin
                        bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_ERROR, '0, '0,
                                                                 '0, '0, pwt_pkg::ERR_ELEMENT));
                        s.err = 1'b1;
                     end else begin
                        bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_END_SEQ, s.cf,
                           (s.sm == pwt_pkg::SEQ_PACKED) ? pwt_pkg::WT_LENGTH : s.cw,
                           '0, '0, pwt_pkg::ERR_NONE));
                        s.sm = pwt_pkg::SEQ_NONE;
                        s.ph = pwt_pkg::PH_TAG;
                     end
                  end
               end
            end
            default: begin
               s.ph = pwt_pkg::PH_TAG;
               v = pwt_pkg::vint(s.acc, s.cnt, req_data.data_byte);
               s.acc = v.acc;
               s.cnt = v.cnt;
               if (v.res == pwt_pkg::VI_LONG) begin
                  bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_ERROR, '0, '0, '0, '0,
                                                           pwt_pkg::ERR_TAG));
                  s.err = 1'b1;
               end else if (v.res == pwt_pkg::VI_DONE) begin
                  tag_f = (s.acc[63:32] != '0) ? pwt_pkg::FIELD_MAX : s.acc[31:3];
                  tag_load = 1'b1;
                  if (s.sm == pwt_pkg::SEQ_UNPACKED &&
                      (tag_f != s.cf || s.acc[2:0] != s.cw)) begin
                     bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_END_SEQ, s.cf, s.cw,
                                                              '0, '0, pwt_pkg::ERR_NONE));
                     s.sm = pwt_pkg::SEQ_NONE;
                  end
                  s.cf  = tag_f;
                  s.cw  = s.acc[2:0];
                  s.acc = '0;
                  s.cnt = '0;
                  case (s.cw)
                     pwt_pkg::WT_VARINT:  s.ph = pwt_pkg::PH_VAL;
                     pwt_pkg::WT_FIXED64: s.ph = pwt_pkg::PH_FIX;
                     pwt_pkg::WT_FIXED32: s.ph = pwt_pkg::PH_FIX;
                     pwt_pkg::WT_LENGTH:  s.ph = pwt_pkg::PH_LEN;
                     default: begin
                        bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_ERROR, '0, '0,
                                                                 '0, '0, pwt_pkg::ERR_WIRE));
                        s.err = 1'b1;
                     end
                  endcase
               end
            end
         endcase

         if (do_cf) begin
            cl = pwt_pkg::classify(s.cw, ent_ff);
            if (cl == pwt_pkg::CL_PACKED) begin
               cl = pwt_pkg::CL_UNKNOWN;
            end
            if (cl != pwt_pkg::CL_REP && s.sm != pwt_pkg::SEQ_NONE) begin
               bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_END_SEQ, s.cf,
                  (s.sm == pwt_pkg::SEQ_PACKED) ? pwt_pkg::WT_LENGTH : s.cw,
                  '0, '0, pwt_pkg::ERR_NONE));
               s.sm = pwt_pkg::SEQ_NONE;
            end
            if (cl == pwt_pkg::CL_REP) begin
               if (s.sm != pwt_pkg::SEQ_UNPACKED) begin
                  bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_START, s.cf, s.cw, '0,
                                                           '0, pwt_pkg::ERR_NONE));
                  s.sm = pwt_pkg::SEQ_UNPACKED;
               end
               bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_FIELD, s.cf, s.cw, cf_val,
                                                        cf_off, pwt_pkg::ERR_NONE));
            end else begin
               bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(
                  (cl == pwt_pkg::CL_FIELD) ? pwt_pkg::TK_FIELD : pwt_pkg::TK_UNKNOWN,
                  s.cf, s.cw, cf_val, cf_off, pwt_pkg::ERR_NONE));
            end
            s.ph  = pwt_pkg::PH_TAG;
            s.acc = '0;
            s.cnt = '0;
         end
      end

      if (take && req_data.operation == pwt_pkg::OP_BYTE) begin
         s.off = s.off + 32'd1;
      end

      if (take && (req_data.operation == pwt_pkg::OP_END ||
                   (req_data.operation == pwt_pkg::OP_BYTE && req_data.end_of_message))) begin
         if (!s.err) begin
            if (s.ph == pwt_pkg::PH_TAG && s.cnt == '0) begin
               if (s.sm != pwt_pkg::SEQ_NONE) begin
                  bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_END_SEQ, s.cf,
                     (s.sm == pwt_pkg::SEQ_PACKED) ? pwt_pkg::WT_LENGTH : s.cw,
                     '0, '0, pwt_pkg::ERR_NONE));
               end
               bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_END_MSG, '0, '0, '0, '0,
                                                        pwt_pkg::ERR_NONE));
            end else begin
               unique case (s.ph)
                  pwt_pkg::PH_VAL:  code = pwt_pkg::ERR_VARINT;
                  pwt_pkg::PH_LEN:  code = pwt_pkg::ERR_LENGTH;
                  pwt_pkg::PH_FIX:  code = (s.cw == pwt_pkg::WT_FIXED64) ?
                                           pwt_pkg::ERR_FIXED64 : pwt_pkg::ERR_FIXED32;
                  pwt_pkg::PH_SKIP: code = pwt_pkg::ERR_OVERRUN;
                  pwt_pkg::PH_PACK: code = pwt_pkg::ERR_OVERRUN;
                  default:          code = pwt_pkg::ERR_TAG;
               endcase
               bnd = pwt_pkg::push(bnd, pwt_pkg::mk_tok(pwt_pkg::TK_ERROR, '0, '0, '0, '0,
                                                        code));
            end
         end
         s = clr;
      end

      if (bnd.n != '0) begin
         bnd.tok[2'(bnd.n - 3'd1)].last_result = 1'b1;
      end
      st_in = s;
   end

   always_comb begin
      ent_in = ent_ff;
      if (take && req_data.operation == pwt_pkg::OP_WRITE) begin
         if (st_ff.cf < 29'(pwt_pkg::FIELD_SLOTS) &&
             st_ff.cf[pwt_pkg::SLOT_W-1:0] == wr_addr) begin
            ent_in = wr_ent;
         end
      end
   end

   assign push_valid = take && (bnd.n != '0);
   assign push_data  = bnd;

   always_ff @(posedge clock) begin
      if (take && req_data.operation == pwt_pkg::OP_WRITE &&
          int'(req_data.slot_index) < pwt_pkg::FIELD_SLOTS) begin
         slot_mem[wr_addr] <= wr_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= '{ph: pwt_pkg::PH_TAG, default: '0};
         valid_ff <= '0;
         ent_ff   <= '0;
      end else begin
         st_ff <= st_in;
         if (take && req_data.operation == pwt_pkg::OP_WRITE &&
             int'(req_data.slot_index) < pwt_pkg::FIELD_SLOTS) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (tag_load) begin
            if (tag_f < 29'(pwt_pkg::FIELD_SLOTS) && valid_ff[rd_addr]) begin
               ent_ff <= slot_mem[rd_addr];
            end else begin
               ent_ff <= '0;
            end
         end else begin
            ent_ff <= ent_in;
         end
      end
   end

endmodule

### design/pwt_queue.sv
// ----------------------------------------------------------------------------
// pwt_queue
// Short queue of token bundles between the parser and the output stage.
// ----------------------------------------------------------------------------
module pwt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  pwt_pkg::bundle_type push_data,
   input  logic                pop,
   output pwt_pkg::bundle_type head,
   output pwt_pkg::qstat_type  qstat
);

   pwt_pkg::bundle_type          q_ff [pwt_pkg::QUEUE_DEPTH];
   logic [pwt_pkg::QPTR_W-1:0]   wp_ff, wp_in;
   logic [pwt_pkg::QPTR_W-1:0]   rp_ff, rp_in;
   logic [pwt_pkg::QPTR_W:0]     cnt_ff, cnt_in;
   logic                         do_pop;

   assign do_pop      = pop && (cnt_ff != '0);
   assign head        = q_ff[rp_ff];
   assign qstat.full  = (cnt_ff == (pwt_pkg::QPTR_W + 1)'(pwt_pkg::QUEUE_DEPTH));
   assign qstat.empty = (cnt_ff == '0);

   always_comb begin
      wp_in  = push_valid ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (push_valid ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         q_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### design/pwt_back.sv
// ----------------------------------------------------------------------------
// pwt_back
// Output stage: sends the tokens of each bundle one per transaction.
// ----------------------------------------------------------------------------
module pwt_back (
   input  logic                clock,
   input  logic                reset,
   input  pwt_pkg::bundle_type head,
   input  pwt_pkg::qstat_type  qstat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pwt_pkg::rsp_type    rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       last;

   assign rsp_valid = !qstat.empty;
   assign rsp_data  = head.tok[idx_ff];
   assign last      = (3'(idx_ff) == head.n - 3'd1);
   assign pop       = rsp_valid && !rsp_stall && last;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_valid && !rsp_stall) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

### design/protobuf_wire_tokenizer.sv
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer
// Protocol buffers wire-format tokenizer, one message byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries message bytes, field table slot writes and empty message ends.
//   Each request transaction yields zero to four tokens on rsp_; the last token
//   of a request has last_result set. Table writes yield no tokens.
//   Output path: the tokens of a request are registered in the bundle queue
//   and reach rsp_ after the tokens of all earlier requests.
//   Throughput: one request per cycle while each produces at most one token and
//   rsp_stall is low; the rsp_ side sends one token per cycle while rsp_stall is
//   low, so requests with several tokens are paced by it. The four-entry bundle
//   queue is what decouples the two sides.
//   Reset clears parser state, the queue and every field table slot (unknown);
//   the block accepts requests in the first cycle after reset.
//   When rsp_stall is high the queue fills and req_stall rises once it holds
//   four bundles; no token is lost or repeated.
// ----------------------------------------------------------------------------
module protobuf_wire_tokenizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pwt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pwt_pkg::rsp_type rsp_data
);

   pwt_pkg::bundle_type push_data;
   pwt_pkg::bundle_type head;
   pwt_pkg::qstat_type  qstat;
   logic                push_valid;
   logic                pop;

   pwt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   pwt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   pwt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### design/pwt_checker.sv
// ----------------------------------------------------------------------------
// pwt_checker
// Port-level checks for the wire tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module pwt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input pwt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pwt_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled transaction changed");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.token == pwt_pkg::TK_ERROR) ==
                     (rsp_data.error_code != pwt_pkg::ERR_NONE)))
      else $error("error code does not match token");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token == pwt_pkg::TK_END_MSG ||
                    rsp_data.token == pwt_pkg::TK_ERROR) |-> rsp_data.last_result)
      else $error("message end or error token not last");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token present after reset");

endmodule

bind protobuf_wire_tokenizer pwt_checker u_pwt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
